// ===== rtl/mcst_pkg.sv =====
// ----------------------------------------------------------------------------
// mcst_pkg
// Shared constants, codes and types of the multi-channel soft timer unit.
// ----------------------------------------------------------------------------
package mcst_pkg;

   localparam int NUM_TIMERS = 16;  // 1 .. 16

   localparam int IDX_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int ALLOC_W = $clog2(NUM_TIMERS + 1);
   localparam int CMP_W   = (ALLOC_W > 4) ? ALLOC_W : 4;

   localparam int CMD_W    = 2;
   localparam int HANDLE_W = 4;
   localparam int PERIOD_W = 32;
   localparam int STATUS_W = 2;
   localparam int MASK_W   = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 2'd0,
      CMD_CREATE = 2'd1,
      CMD_START  = 2'd2,
      CMD_STOP   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SWEEP,
      S_FINISH
   } state_type;

   // Control from the sequencer to the timer datapath
   typedef struct packed {
      logic                rd_en;
      logic [IDX_W-1:0]    rd_addr;
      logic                upd_en;
      logic [IDX_W-1:0]    upd_addr;
      logic                upd_run;
      logic                clr_en;
      logic [IDX_W-1:0]    clr_addr;
      logic                per_wr_en;
      logic [IDX_W-1:0]    per_wr_addr;
      logic [PERIOD_W-1:0] per_wr_data;
   } dp_ctrl_type;

endpackage

// ===== rtl/mcst_req_if.sv =====
// ----------------------------------------------------------------------------
// mcst_req_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface mcst_req_if;
   logic                          valid;
   logic                          ready;
   logic [mcst_pkg::CMD_W-1:0]    cmd;
   logic [mcst_pkg::HANDLE_W-1:0] handle;
   logic [mcst_pkg::PERIOD_W-1:0] timeout;
   logic                          start_now;

   modport source (output valid, cmd, handle, timeout, start_now, input ready);
   modport sink   (input valid, cmd, handle, timeout, start_now, output ready);
endinterface

// ===== rtl/mcst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mcst_rsp_if
// Result channel: valid/ready handshake with status, handle and expiry mask.
// ----------------------------------------------------------------------------
interface mcst_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mcst_pkg::STATUS_W-1:0] status;
   logic [mcst_pkg::HANDLE_W-1:0] new_handle;
   logic [mcst_pkg::MASK_W-1:0]   expired_mask;

   modport source (output valid, status, new_handle, expired_mask, input ready);
   modport sink   (input valid, status, new_handle, expired_mask, output ready);
endinterface

// ===== rtl/multi_channel_soft_timer_unit.sv =====
// ----------------------------------------------------------------------------
// multi_channel_soft_timer_unit
// Table of periodic timers driven by tick, create, start and stop commands.
// ----------------------------------------------------------------------------
// Every command returns exactly one result. Create, start and stop are
// accepted in the idle state and their result is loaded into the output
// register from the finish state once that register is free. A tick walks
// the whole table through one read port of the counter and period memories
// and one shared increment-and-compare unit, one timer per cycle, before its
// result goes the same way. The command port is ready only while the
// sequencer is idle; the result register lets the next command in while an
// earlier result still waits to be taken. No clearing pass is needed after
// reset.
module multi_channel_soft_timer_unit (
   input  logic       clock,
   input  logic       reset,
   mcst_req_if.sink   req_bus,
   mcst_rsp_if.source rsp_bus
);

   mcst_pkg::dp_ctrl_type dp_ctrl;
   logic                  dp_hit;

   mcst_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .dp_ctrl (dp_ctrl),
      .dp_hit  (dp_hit)
   );

   mcst_timer_dp u_dp (
      .clock (clock),
      .ctrl  (dp_ctrl),
      .hit   (dp_hit)
   );

endmodule

// ===== rtl/mcst_timer_dp.sv =====
// ----------------------------------------------------------------------------
// mcst_timer_dp
// Counter and period memories with the shared increment and compare unit.
// ----------------------------------------------------------------------------
module mcst_timer_dp (
   input  logic                  clock,
   input  mcst_pkg::dp_ctrl_type ctrl,
   output logic                  hit
);

   logic [mcst_pkg::PERIOD_W-1:0] count_mem  [mcst_pkg::NUM_TIMERS];
   logic [mcst_pkg::PERIOD_W-1:0] period_mem [mcst_pkg::NUM_TIMERS];

   logic [mcst_pkg::PERIOD_W-1:0] count_rd_ff;
   logic [mcst_pkg::PERIOD_W-1:0] period_rd_ff;
   logic [mcst_pkg::PERIOD_W:0]   count_next;

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         count_rd_ff  <= count_mem[ctrl.rd_addr];
         period_rd_ff <= period_mem[ctrl.rd_addr];
      end
   end

   // Increment with carry so an all-ones count still compares correctly
   assign count_next = {1'b0, count_rd_ff} + (mcst_pkg::PERIOD_W + 1)'(1);
   assign hit        = (count_next >= {1'b0, period_rd_ff});

   always_ff @(posedge clock) begin
      if (ctrl.clr_en) begin
         count_mem[ctrl.clr_addr] <= '0;
      end else if (ctrl.upd_en && ctrl.upd_run) begin
         count_mem[ctrl.upd_addr] <= hit ? '0 : count_next[mcst_pkg::PERIOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.per_wr_en) begin
         period_mem[ctrl.per_wr_addr] <= ctrl.per_wr_data;
      end
   end

endmodule

// ===== rtl/mcst_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcst_ctrl
// Command sequencer: run flags, allocation count, tick sweep and result
// register.
// ----------------------------------------------------------------------------
module mcst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   mcst_req_if.sink              req_bus,
   mcst_rsp_if.source            rsp_bus,
   output mcst_pkg::dp_ctrl_type dp_ctrl,
   input  logic                  dp_hit
);

   localparam logic [mcst_pkg::IDX_W-1:0]   LAST_IDX =
      mcst_pkg::IDX_W'(mcst_pkg::NUM_TIMERS - 1);
   localparam logic [mcst_pkg::ALLOC_W-1:0] FULL_CNT =
      mcst_pkg::ALLOC_W'(mcst_pkg::NUM_TIMERS);

   mcst_pkg::state_type state_ff, state_in;

   logic [mcst_pkg::NUM_TIMERS-1:0] running_ff, running_in;
   logic [mcst_pkg::ALLOC_W-1:0]    allocated_ff, allocated_in;
   logic [mcst_pkg::IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                            issue_ff, issue_in;
   logic                            upd_valid_ff, upd_valid_in;
   logic [mcst_pkg::IDX_W-1:0]      upd_idx_ff, upd_idx_in;
   logic [mcst_pkg::MASK_W-1:0]     mask_ff, mask_in;
   logic [mcst_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [mcst_pkg::HANDLE_W-1:0]   nh_ff, nh_in;
   logic                            out_valid_ff, out_valid_in;
   logic [mcst_pkg::STATUS_W-1:0]   out_status_ff, out_status_in;
   logic [mcst_pkg::HANDLE_W-1:0]   out_nh_ff, out_nh_in;
   logic [mcst_pkg::MASK_W-1:0]     out_mask_ff, out_mask_in;

   logic                            found;
   logic [mcst_pkg::IDX_W-1:0]      req_idx;
   logic [mcst_pkg::IDX_W-1:0]      new_idx;
   logic [mcst_pkg::NUM_TIMERS:0]   alloc_span;

   assign found   = (mcst_pkg::CMP_W'(req_bus.handle) < mcst_pkg::CMP_W'(allocated_ff));
   assign req_idx = mcst_pkg::IDX_W'(req_bus.handle);
   assign new_idx = mcst_pkg::IDX_W'(allocated_ff);

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.status       = out_status_ff;
   assign rsp_bus.new_handle   = out_nh_ff;
   assign rsp_bus.expired_mask = out_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcst_pkg::S_IDLE;
         running_ff   <= '0;
         allocated_ff <= '0;
         issue_ff     <= 1'b0;
         upd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         allocated_ff <= allocated_in;
         issue_ff     <= issue_in;
         upd_valid_ff <= upd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      upd_idx_ff    <= upd_idx_in;
      mask_ff       <= mask_in;
      status_ff     <= status_in;
      nh_ff         <= nh_in;
      out_status_ff <= out_status_in;
      out_nh_ff     <= out_nh_in;
      out_mask_ff   <= out_mask_in;
   end

   always_comb begin
      state_in      = state_ff;
      running_in    = running_ff;
      allocated_in  = allocated_ff;
      rd_idx_in     = rd_idx_ff;
      issue_in      = 1'b0;
      upd_valid_in  = 1'b0;
      upd_idx_in    = rd_idx_ff;
      mask_in       = mask_ff;
      status_in     = status_ff;
      nh_in         = nh_ff;
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      out_status_in = out_status_ff;
      out_nh_in     = out_nh_ff;
      out_mask_in   = out_mask_ff;
      req_bus.ready = 1'b0;

      dp_ctrl             = '0;
      dp_ctrl.rd_addr     = rd_idx_ff;
      dp_ctrl.upd_addr    = upd_idx_ff;
      dp_ctrl.upd_run     = running_ff[upd_idx_ff];
      dp_ctrl.clr_addr    = req_idx;
      dp_ctrl.per_wr_addr = new_idx;
      dp_ctrl.per_wr_data = req_bus.timeout;

      unique case (state_ff)
         mcst_pkg::S_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               status_in = mcst_pkg::STAT_OK;
               nh_in     = '0;
               mask_in   = '0;
               state_in  = mcst_pkg::S_FINISH;
               unique case (mcst_pkg::cmd_type'(req_bus.cmd)) inside
                  mcst_pkg::CMD_TICK: begin
                     state_in  = mcst_pkg::S_SWEEP;
                     rd_idx_in = '0;
                     issue_in  = 1'b1;
                  end
                  mcst_pkg::CMD_CREATE: begin
                     if (allocated_ff == FULL_CNT) begin
                        status_in = mcst_pkg::STAT_FULL;
                     end else begin
                        dp_ctrl.clr_en      = 1'b1;
                        dp_ctrl.clr_addr    = new_idx;
                        dp_ctrl.per_wr_en   = 1'b1;
                        running_in[new_idx] = req_bus.start_now;
                        allocated_in        = allocated_ff + mcst_pkg::ALLOC_W'(1);
                        nh_in               = mcst_pkg::HANDLE_W'(allocated_ff);
                     end
                  end
                  mcst_pkg::CMD_START, mcst_pkg::CMD_STOP: begin
                     if (found) begin
                        dp_ctrl.clr_en      = 1'b1;
                        running_in[req_idx] = (req_bus.cmd == mcst_pkg::CMD_START);
                     end else begin
                        status_in = mcst_pkg::STAT_NOT_FOUND;
                     end
                  end
                  default: begin
                     state_in = mcst_pkg::S_FINISH;
                  end
               endcase
            end
         end

         mcst_pkg::S_SWEEP: begin
            // Read one entry a cycle; update the entry read in the cycle before
            dp_ctrl.rd_en  = issue_ff;
            dp_ctrl.upd_en = upd_valid_ff;
            upd_valid_in   = issue_ff;
            upd_idx_in     = rd_idx_ff;
            if (issue_ff && (rd_idx_ff != LAST_IDX)) begin
               issue_in  = 1'b1;
               rd_idx_in = rd_idx_ff + mcst_pkg::IDX_W'(1);
            end
            if (upd_valid_ff && running_ff[upd_idx_ff] && dp_hit) begin
               mask_in = mask_ff | (mcst_pkg::MASK_W'(1) << upd_idx_ff);
            end
            if (upd_valid_ff && (upd_idx_ff == LAST_IDX)) begin
               state_in = mcst_pkg::S_FINISH;
            end
         end

         mcst_pkg::S_FINISH: begin
            // Hold until the result register is free
            if (!out_valid_ff || rsp_bus.ready) begin
               out_valid_in  = 1'b1;
               out_status_in = status_ff;
               out_nh_in     = nh_ff;
               out_mask_in   = mask_ff;
               state_in      = mcst_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = mcst_pkg::S_IDLE;
         end
      endcase
   end

   assign alloc_span = ((mcst_pkg::NUM_TIMERS + 1)'(1) << allocated_ff)
                       - (mcst_pkg::NUM_TIMERS + 1)'(1);

   a_alloc_bound: assert property (@(posedge clock) disable iff (reset)
      allocated_ff <= FULL_CNT)
      else $error("allocation count beyond table size");

   a_run_alloc: assert property (@(posedge clock) disable iff (reset)
      (running_ff & ~alloc_span[mcst_pkg::NUM_TIMERS-1:0]) == '0)
      else $error("unallocated timer marked running");

   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcst_pkg::S_SWEEP) && upd_valid_ff && (upd_idx_ff == LAST_IDX)
      |=> (state_ff == mcst_pkg::S_FINISH))
      else $error("tick sweep did not finish after last entry");

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(dp_ctrl.clr_en && dp_ctrl.upd_en))
      else $error("counter clear and sweep update in same cycle");

   a_err_payload: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_status_ff != mcst_pkg::STAT_OK)
      |-> (out_nh_ff == '0) && (out_mask_ff == '0))
      else $error("failed command carries handle or expiry bits");

endmodule
